[src/des_pkg.sv]
// ----------------------------------------------------------------------------
// des_pkg: shared types, tables and functions for the des block encryptor
// permutation tables, s-boxes and the round function in standard bit order
// ----------------------------------------------------------------------------
package des_pkg;

  typedef logic [63:0] blk_t;
  typedef logic [55:0] cd_t;
  typedef logic [47:0] subkey_t;

  // pipeline word handed from one round cell to the next
  typedef struct packed {
    logic        vld;
    logic [31:0] l;
    logic [31:0] r;
    cd_t         cd;
  } stage_t;

  localparam int unsigned MaxRounds = 16;

  // register index of the key
  localparam logic RegKey = 1'b0;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [7:0] TabIpInv [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] TabExp [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] TabPerm [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] TabShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] TabSbox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // initial permutation
  function automatic blk_t perm_ip(blk_t x);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TabIp[i])];
    return r;
  endfunction

  // inverse initial permutation
  function automatic blk_t perm_ipinv(blk_t x);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TabIpInv[i])];
    return r;
  endfunction

  // key selection to 56 bits, parity dropped
  function automatic cd_t perm_pc1(blk_t x);
    cd_t r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64 - int'(TabPc1[i])];
    return r;
  endfunction

  // subkey selection from the rotated halves
  function automatic subkey_t perm_pc2(cd_t x);
    subkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56 - int'(TabPc2[i])];
    return r;
  endfunction

  // rotate both 28-bit halves left by one or two
  function automatic cd_t rot_cd(cd_t x, logic [1:0] n);
    logic [27:0] c;
    logic [27:0] d;
    c = x[55:28];
    d = x[27:0];
    if (n == 2'd2) begin
      c = {c[25:0], c[27:26]};
      d = {d[25:0], d[27:26]};
    end else begin
      c = {c[26:0], c[27]};
      d = {d[26:0], d[27]};
    end
    return {c, d};
  endfunction

  // feistel function: expand, mix subkey, s-boxes, permute
  function automatic logic [31:0] feistel(logic [31:0] r, subkey_t sub);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabExp[i])];
    x = x ^ sub;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = TabSbox[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TabPerm[i])];
    return p;
  endfunction

endpackage

[src/des_round.sv]
// ----------------------------------------------------------------------------
// des_round: one pipeline cell of the des rounds
// rotates the key halves, forms the subkey and runs one feistel round
// ----------------------------------------------------------------------------
module des_round #(
  parameter int unsigned Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  des_pkg::stage_t stage_i,
  output des_pkg::stage_t stage_o
);
  import des_pkg::*;

  localparam logic [1:0] Shift = TabShift[Idx % MaxRounds];

  cd_t         cd_rot;
  logic [31:0] f_out;
  logic        vld_q;
  logic [31:0] l_q, r_q;
  cd_t         cd_q;

  // round logic
  assign cd_rot = rot_cd(stage_i.cd, Shift);
  assign f_out  = feistel(stage_i.r, perm_pc2(cd_rot));

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q  <= stage_i.r;
      r_q  <= stage_i.l ^ f_out;
      cd_q <= cd_rot;
    end
  end

  assign stage_o = '{vld: vld_q, l: l_q, r: r_q, cd: cd_q};

endmodule

[src/des_block_encrypt.sv]
// ----------------------------------------------------------------------------
// des_block_encrypt: pipelined des encryption, one round cell per stage
// an accepted block passes through every round cell register, then the output register
// throughput one block per cycle; the whole chain stalls when output is held
// reset clears the key register and all stage valid bits
// ----------------------------------------------------------------------------
module des_block_encrypt #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        plaintext_valid_i,
  output logic        plaintext_ready_o,
  input  logic [63:0] plaintext_i,
  output logic        ciphertext_valid_o,
  input  logic        ciphertext_ready_i,
  output logic [63:0] ciphertext_o
);
  import des_pkg::*;

  logic [63:0] key_q;
  logic        en;
  logic [63:0] ip_blk;
  stage_t      chain [ROUNDS+1];
  logic        out_vld_q;
  logic [63:0] out_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegKey) ? key_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= 64'd0;
    end else if (psel && penable && pwrite && paddr[3] == RegKey) begin
      key_q <= pwdata;
    end
  end

  // chain advances unless the output register is full and held
  assign en = !out_vld_q || ciphertext_ready_i;
  assign plaintext_ready_o = en;

  // chain entry
  assign ip_blk = perm_ip(plaintext_i);
  assign chain[0] = '{vld: plaintext_valid_i, l: ip_blk[63:32], r: ip_blk[31:0],
                      cd: perm_pc1(key_q)};

  // round cells
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    des_round #(.Idx(g)) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .stage_i(chain[g]),
      .stage_o(chain[g+1])
    );
  end

  // output register with final swap and inverse permutation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[ROUNDS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= perm_ipinv({chain[ROUNDS].r, chain[ROUNDS].l});
    end
  end

  assign ciphertext_valid_o = out_vld_q;
  assign ciphertext_o       = out_q;

endmodule

[bench/tb_des_block_encrypt.sv]
// ----------------------------------------------------------------------------
// tb_des_block_encrypt: self-checking bench for the pipelined des encryptor
// plaintext blocks go in under a sequence of keys, a local des model predicts
// each ciphertext, and a scoreboard compares every output transfer in order
// ----------------------------------------------------------------------------
module tb_des_block_encrypt;
  import des_pkg::*;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam logic [3:0]  AddrKey   = 4'd0;
  localparam logic [3:0]  AddrSpare = 4'd8;

  // cipher model and in-order store of expected ciphertext
  class des_scoreboard;
    blk_t key;
    blk_t ct_queue[$];
    int   errors;

    function new();
      key    = '0;
      errors = 0;
    endfunction

    // one des encryption under the current key
    function blk_t encrypt(blk_t pt);
      blk_t        ipd;
      blk_t        pre;
      blk_t        res;
      logic [27:0] c;
      logic [27:0] d;
      logic [55:0] cd;
      logic [47:0] sub;
      logic [47:0] ex;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] s;
      logic [31:0] f;
      logic [31:0] t;
      logic [5:0]  six;
      int          sh;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(TabPc1[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 64; i++) ipd[63-i] = pt[64 - int'(TabIp[i])];
      l = ipd[63:32];
      r = ipd[31:0];
      for (int k = 0; k < NumRounds; k++) begin
        sh = int'(TabShift[k % 16]);
        repeat (sh) begin
          c = {c[26:0], c[27]};
          d = {d[26:0], d[27]};
        end
        cd = {c, d};
        for (int i = 0; i < 48; i++) sub[47-i] = cd[56 - int'(TabPc2[i])];
        for (int i = 0; i < 48; i++) ex[47-i] = r[32 - int'(TabExp[i])];
        ex = ex ^ sub;
        for (int i = 0; i < 8; i++) begin
          six = ex[47-6*i -: 6];
          s[31-4*i -: 4] = TabSbox[i][{six[5], six[0]} * 16 + six[4:1]];
        end
        for (int i = 0; i < 32; i++) f[31-i] = s[32 - int'(TabPerm[i])];
        t = l ^ f;
        l = r;
        r = t;
      end
      pre = {r, l};
      for (int i = 0; i < 64; i++) res[63-i] = pre[64 - int'(TabIpInv[i])];
      return res;
    endfunction

    function void note_plaintext(blk_t pt);
      ct_queue.push_back(encrypt(pt));
    endfunction

    function void check_ciphertext(blk_t ct);
      blk_t exp_ct;
      if (ct_queue.size() == 0) begin
        $error("ciphertext: unexpected transfer, actual %h", ct);
        errors++;
      end else begin
        exp_ct = ct_queue.pop_front();
        if (exp_ct !== ct) begin
          $error("ciphertext: expected %h actual %h", exp_ct, ct);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        plaintext_valid_i = 1'b0;
  logic        plaintext_ready_o;
  logic [63:0] plaintext_i = '0;
  logic        ciphertext_valid_o;
  logic        ciphertext_ready_i = 1'b0;
  logic [63:0] ciphertext_o;

  des_scoreboard sb = new();
  bit            fast_sender;
  bit            fast_receiver;
  int            idle_cycles;

  des_block_encrypt #(.ROUNDS(NumRounds)) i_dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int draw_gap(bit fast);
    if (fast) return 0;
    return $urandom_range(0, 8);
  endfunction

  // apb write: setup then access
  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrKey) sb.key = data;
  endtask

  // one plaintext transfer, after a random gap unless the sender is fast
  task automatic send_block(blk_t pt);
    int gap;
    bit acc;
    gap = draw_gap(fast_sender);
    if (gap > 0) begin
      plaintext_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    plaintext_valid_i <= 1'b1;
    plaintext_i       <= pt;
    do begin
      @(negedge clk_i);
      acc = plaintext_valid_i && plaintext_ready_o;
      @(posedge clk_i);
    end while (!acc);
    sb.note_plaintext(pt);
  endtask

  // wait for the pipeline to drain before touching the key
  task automatic drain();
    plaintext_valid_i <= 1'b0;
    while (sb.ct_queue.size() != 0) @(posedge clk_i);
    repeat (NumRounds + 4) @(posedge clk_i);
  endtask

  // receiver with random stalls
  initial begin
    int gap;
    bit acc;
    blk_t ct;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(fast_receiver);
      if (gap > 0) begin
        ciphertext_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      ciphertext_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        acc = ciphertext_valid_o && ciphertext_ready_i;
        ct  = ciphertext_o;
        @(posedge clk_i);
      end while (!acc);
      sb.check_ciphertext(ct);
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((plaintext_valid_i && plaintext_ready_o) ||
        (ciphertext_valid_o && ciphertext_ready_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    blk_t keys[$];
    blk_t directed[$];
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks under the reset key
    directed = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF};
    fast_sender   = 1'b1;
    fast_receiver = 1'b0;
    foreach (directed[i]) send_block(directed[i]);
    drain();

    // standard test key, weak keys, and weak keys with parity bits flipped (all ones, all zeros)
    keys = '{64'h1334_5779_9BBC_DFF1, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
             64'h0000_0000_0000_0000, 64'h1F1F_1F1F_0E0E_0E0E};
    repeat (6) keys.push_back({$urandom, $urandom});

    foreach (keys[k]) begin
      apb_write(AddrKey, keys[k]);
      // write to an unmapped index must leave the key alone
      if (k % 3 == 0) apb_write(AddrSpare, {$urandom, $urandom});
      fast_sender   = $urandom_range(0, 3) == 0;
      fast_receiver = $urandom_range(0, 3) == 0;
      if (k == 0) begin
        foreach (directed[i]) send_block(directed[i]);
      end
      repeat (150) send_block({$urandom, $urandom});
      drain();
    end

    if (sb.errors == 0 && sb.ct_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sb.ct_queue.size() != 0) $error("ciphertext: %0d expected left", sb.ct_queue.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[des_block_encrypt.f]
src/des_pkg.sv
src/des_round.sv
src/des_block_encrypt.sv
bench/tb_des_block_encrypt.sv
